### rtl/tcs_pkg.sv
// Package for the telnet command stripper: protocol byte codes, register
// indexes and reset values, and the result word type.
// Depends on nothing; the stripper unit uses it.
`default_nettype none

package tcs_pkg;

	// Telnet command bytes.
	localparam logic [7:0] B_IAC  = 8'hFF;
	localparam logic [7:0] B_DONT = 8'hFE;
	localparam logic [7:0] B_DO   = 8'hFD;
	localparam logic [7:0] B_WONT = 8'hFC;
	localparam logic [7:0] B_WILL = 8'hFB;
	localparam logic [7:0] B_SB   = 8'hFA;
	localparam logic [7:0] B_SE   = 8'hF0;

	// Configuration registers.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 64;
	localparam logic [CFG_INDEX_W-1:0] CFG_WILL_MASK = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DO_MASK   = 1'd1;
	localparam logic [CFG_DATA_W-1:0] WILL_MASK_RESET = 64'd106;
	localparam logic [CFG_DATA_W-1:0] DO_MASK_RESET   = 64'd2164260874;

	// Verb waiting for its option byte, in the order of the command codes.
	localparam logic [1:0] PV_WILL = 2'd0;
	localparam logic [1:0] PV_WONT = 2'd1;
	localparam logic [1:0] PV_DO   = 2'd2;
	localparam logic [1:0] PV_DONT = 2'd3;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       reply_valid;
		logic [7:0] reply_verb;
		logic [7:0] reply_option;
	} result_t;

endpackage

`default_nettype wire

### rtl/tcs_channels.sv
// Handshake channels of the telnet command stripper: the received byte
// stream and the result stream. Uses tcs_pkg for nothing but keeps its widths.
// Each channel moves one word when valid and ready are both high.
`default_nettype none

interface tcs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcs_res_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       reply_valid;
	logic [7:0] reply_verb;
	logic [7:0] reply_option;

	modport source (output valid, output data_valid, output data_byte,
		output reply_valid, output reply_verb, output reply_option, input ready);
	modport sink   (input valid, input data_valid, input data_byte,
		input reply_valid, input reply_verb, input reply_option, output ready);
endinterface

`default_nettype wire

### rtl/telnet_command_stripper_unit.sv
// Telnet command stripper: removes IAC command sequences from a received
// byte stream and answers WILL/DO option negotiation. An accepted byte goes
// through the input register to the result register; one byte is taken every
// cycle while the result is not stalled, the phase being updated in between.
// Reset (arst_n low, asynchronous) returns to the plain data phase, empties
// both registers and loads the default acceptance masks.
// Depends on tcs_pkg and the channel interfaces in tcs_channels.sv.
`default_nettype none

module telnet_command_stripper_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tcs_rx_if.sink                             rx,
	tcs_res_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [tcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [2:0] PH_DATA   = 3'd0;
	localparam logic [2:0] PH_IAC    = 3'd1;
	localparam logic [2:0] PH_OPT    = 3'd2;
	localparam logic [2:0] PH_SUB    = 3'd3;
	localparam logic [2:0] PH_SUBIAC = 3'd4;

	logic [tcs_pkg::CFG_DATA_W-1:0] will_mask_q;
	logic [tcs_pkg::CFG_DATA_W-1:0] do_mask_q;
	logic [2:0]                     phase_q;
	logic [1:0]                     pending_verb_q;

	logic                           valid_s1;
	logic [7:0]                     byte_s1;
	logic                           res_valid_q;
	tcs_pkg::result_t               res_q;

	logic                           advance;
	logic [2:0]                     phase_d;
	logic [1:0]                     pending_verb_d;
	tcs_pkg::result_t               res_d;
	logic                           opt_low;

	// The input register doubles as the skid stage when the result is stalled.
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign opt_low  = (byte_s1[7:6] == 2'b00);

	always_comb begin
		phase_d        = phase_q;
		pending_verb_d = pending_verb_q;
		res_d          = '0;
		unique case (phase_q)
			PH_IAC: begin
				if (byte_s1 == tcs_pkg::B_IAC) begin
					res_d.data_valid = 1'b1;
					res_d.data_byte  = tcs_pkg::B_IAC;
					phase_d          = PH_DATA;
				end else if (byte_s1 >= tcs_pkg::B_WILL && byte_s1 <= tcs_pkg::B_DONT) begin
					// WILL..DONT map onto 0..3 by adding one to the low bits.
					pending_verb_d = byte_s1[1:0] + 2'd1;
					phase_d        = PH_OPT;
				end else if (byte_s1 == tcs_pkg::B_SB) begin
					phase_d = PH_SUB;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_OPT: begin
				if (pending_verb_q == tcs_pkg::PV_WILL) begin
					res_d.reply_valid  = 1'b1;
					res_d.reply_verb   = (opt_low && will_mask_q[byte_s1[5:0]]) ?
						tcs_pkg::B_DO : tcs_pkg::B_DONT;
					res_d.reply_option = byte_s1;
				end else if (pending_verb_q == tcs_pkg::PV_DO) begin
					res_d.reply_valid  = 1'b1;
					res_d.reply_verb   = (opt_low && do_mask_q[byte_s1[5:0]]) ?
						tcs_pkg::B_WILL : tcs_pkg::B_WONT;
					res_d.reply_option = byte_s1;
				end
				phase_d = PH_DATA;
			end
			PH_SUB: begin
				if (byte_s1 == tcs_pkg::B_IAC) begin
					phase_d = PH_SUBIAC;
				end
			end
			PH_SUBIAC: begin
				phase_d = (byte_s1 == tcs_pkg::B_SE) ? PH_DATA : PH_SUB;
			end
			default: begin
				// Plain data; unused phase codes behave the same way.
				if (byte_s1 == tcs_pkg::B_IAC) begin
					phase_d = PH_IAC;
				end else begin
					res_d.data_valid = 1'b1;
					res_d.data_byte  = byte_s1;
					phase_d          = PH_DATA;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			will_mask_q    <= tcs_pkg::WILL_MASK_RESET;
			do_mask_q      <= tcs_pkg::DO_MASK_RESET;
			phase_q        <= PH_DATA;
			pending_verb_q <= tcs_pkg::PV_WILL;
			valid_s1       <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tcs_pkg::CFG_WILL_MASK: will_mask_q <= cfg_data;
					tcs_pkg::CFG_DO_MASK:   do_mask_q   <= cfg_data;
					default: ;
				endcase
			end
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				phase_q        <= phase_d;
				pending_verb_q <= pending_verb_d;
				res_valid_q    <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.data_valid   = res_q.data_valid;
	assign res.data_byte    = res_q.data_byte;
	assign res.reply_valid  = res_q.reply_valid;
	assign res.reply_verb   = res_q.reply_verb;
	assign res.reply_option = res_q.reply_option;

	// A result word carries payload or a reply, never both.
	a_single_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.data_valid && res_q.reply_valid))
		else $error("result carries both data and reply");

	// Reply fields of a result word without a reply read as zero.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.reply_valid |->
		res_q.reply_verb == 8'd0 && res_q.reply_option == 8'd0)
		else $error("reply fields not cleared");

	// Options of 64 and above are always refused.
	a_high_refused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.reply_valid && res_q.reply_option[7:6] != 2'b00 |->
		res_q.reply_verb == tcs_pkg::B_DONT || res_q.reply_verb == tcs_pkg::B_WONT)
		else $error("high option accepted");

	// A reply only follows a byte taken in the option phase.
	a_reply_source: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_d.reply_valid |-> phase_q == PH_OPT && phase_d == PH_DATA)
		else $error("reply outside option phase");

endmodule

`default_nettype wire
